FILE: hdl/rmq_pkg.sv
// payload types for the rotation matrix to quaternion block
`timescale 1ns / 1ps

package rmq_pkg;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;
  } quat_t;

  localparam int unsigned OutW = 16;
  localparam int unsigned CompMax = 32768;
  localparam int unsigned PosMax = 32767;

endpackage

FILE: hdl/rotation_matrix_to_quaternion_top.sv
// rotation matrix to unit quaternion, fully pipelined
`timescale 1ns / 1ps
// throughput: one matrix per cycle while the skid register is empty; the root takes one bit per
//   stage and each of the four dividers one quotient bit per stage
// a one-entry skid register holds a result the consumer does not take; while it is full
//   the pipeline holds and in_ready_o is low
// reset (rst_ni low, asynchronous) clears all valid bits and the skid register

module rotation_matrix_to_quaternion_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rmq_pkg::mat_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rmq_pkg::quat_t out_data_o
);
  import rmq_pkg::*;

  localparam int unsigned MW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int unsigned VW  = MW + 1;
  localparam int unsigned SW  = 2 * MW + 2;
  localparam int unsigned RW  = MW + 1;
  localparam int unsigned QB  = FRAC_BITS + 1;
  localparam int unsigned NW  = MW + FRAC_BITS + 2;
  localparam int unsigned QW  = (QB > 17) ? QB : 17;
  localparam int unsigned NST = RW + FRAC_BITS + 6;
  localparam int unsigned LST = NST - 1;

  logic en;
  logic [NST-1:0] vld_q;
  logic skid_q, skid_d;
  quat_t skid_data_q, out_q;

  assign en = !skid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: branch select and unnormalized vector
  logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [VW-1:0] tr, a;
  logic signed [VW-1:0] v [4];
  logic signed [VW-1:0] one;
  logic [3:0][MW-1:0] mag_d, s1_mag_q, s2_mag_q;
  logic [4:0] ns_d, s1_ns_q, s2_ns_q, s3_ns_q;

  always_comb begin
    one = VW'(1) <<< FRAC_BITS;
    e00 = VW'(in_data_i.m00);
    e01 = VW'(in_data_i.m01);
    e02 = VW'(in_data_i.m02);
    e10 = VW'(in_data_i.m10);
    e11 = VW'(in_data_i.m11);
    e12 = VW'(in_data_i.m12);
    e20 = VW'(in_data_i.m20);
    e21 = VW'(in_data_i.m21);
    e22 = VW'(in_data_i.m22);
    tr = e00 + e11 + e22;
    if (tr > 0) begin
      a = one + tr;
      v[0] = a; v[1] = e21 - e12; v[2] = e02 - e20; v[3] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      a = one + e00 - e11 - e22;
      v[0] = e21 - e12; v[1] = a; v[2] = e01 + e10; v[3] = e02 + e20;
    end else if (e11 > e22) begin
      a = one + e11 - e00 - e22;
      v[0] = e02 - e20; v[1] = e01 + e10; v[2] = a; v[3] = e12 + e21;
    end else begin
      a = one + e22 - e00 - e11;
      v[0] = e10 - e01; v[1] = e02 + e20; v[2] = e12 + e21; v[3] = a;
    end
    ns_d[4] = a[VW-1] || (a == '0);
    for (int c = 0; c < 4; c++) begin
      ns_d[c] = v[c][VW-1];
      mag_d[c] = v[c][VW-1] ? MW'(-v[c]) : MW'(v[c]);
    end
  end

  logic [2*MW-1:0] sq_q [4];
  logic [SW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mag_q <= mag_d;
      s1_ns_q  <= ns_d;
      for (int c = 0; c < 4; c++) begin
        sq_q[c] <= (2*MW)'(s1_mag_q[c]) * (2*MW)'(s1_mag_q[c]);
      end
      s2_mag_q <= s1_mag_q;
      s2_ns_q  <= s1_ns_q;
      sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
      s3_ns_q <= s2_ns_q;
    end
  end

  logic [3:0][MW-1:0] s3_mag_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_mag_q <= s2_mag_q;
    end
  end

  // integer square root, one result bit per stage
  logic [SW-1:0] sr_rem_q [RW];
  logic [RW-1:0] sr_root_q [RW];
  logic [3:0][MW-1:0] sr_mag_q [RW];
  logic [4:0] sr_ns_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int unsigned I = RW - 1 - k;
    logic [SW-1:0] rem_in, trial;
    logic [RW-1:0] root_in;
    logic [3:0][MW-1:0] mag_in;
    logic [4:0] ns_in;
    if (k == 0) begin : g_first
      assign rem_in = sum_q;
      assign root_in = '0;
      assign mag_in = s3_mag_q;
      assign ns_in = s3_ns_q;
    end else begin : g_next
      assign rem_in = sr_rem_q[k-1];
      assign root_in = sr_root_q[k-1];
      assign mag_in = sr_mag_q[k-1];
      assign ns_in = sr_ns_q[k-1];
    end
    assign trial = (SW'(root_in) << (I + 1)) + (SW'(1) << (2 * I));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_in >= trial) begin
          sr_rem_q[k] <= rem_in - trial;
          sr_root_q[k] <= root_in | (RW'(1) << I);
        end else begin
          sr_rem_q[k] <= rem_in;
          sr_root_q[k] <= root_in;
        end
        sr_mag_q[k] <= mag_in;
        sr_ns_q[k] <= ns_in;
      end
    end
  end

  // divider setup: numerator is mag*2^F + n/2, high part is below n
  logic [RW-1:0] dp_rem_q [4];
  logic [QB-1:0] dp_w_q [4];
  logic [RW-1:0] dp_n_q;
  logic [4:0] dp_ns_q;
  logic [NW-1:0] num [4];
  logic [RW-1:0] nroot;

  assign nroot = sr_root_q[RW-1];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      num[c] = (NW'(sr_mag_q[RW-1][c]) << FRAC_BITS) + NW'(nroot >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        dp_rem_q[c] <= RW'(num[c] >> QB);
        dp_w_q[c] <= num[c][QB-1:0];
      end
      dp_n_q <= nroot;
      dp_ns_q <= sr_ns_q[RW-1];
    end
  end

  // four restoring dividers, one quotient bit per stage
  logic [RW-1:0] dv_rem_q [QB][4];
  logic [QB-1:0] dv_w_q [QB][4];
  logic [RW-1:0] dv_n_q [QB];
  logic [4:0] dv_ns_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0] rem_in [4];
    logic [QB-1:0] w_in [4];
    logic [RW-1:0] n_in;
    logic [4:0] ns_in;
    logic [RW:0] r2 [4];
    if (j == 0) begin : g_first
      assign rem_in = dp_rem_q;
      assign w_in = dp_w_q;
      assign n_in = dp_n_q;
      assign ns_in = dp_ns_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[j-1];
      assign w_in = dv_w_q[j-1];
      assign n_in = dv_n_q[j-1];
      assign ns_in = dv_ns_q[j-1];
    end
    always_comb begin
      for (int c = 0; c < 4; c++) begin
        r2[c] = {rem_in[c], w_in[c][QB-1]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < 4; c++) begin
          if (r2[c] >= {1'b0, n_in}) begin
            dv_rem_q[j][c] <= RW'(r2[c] - {1'b0, n_in});
            dv_w_q[j][c] <= {w_in[c][QB-2:0], 1'b1};
          end else begin
            dv_rem_q[j][c] <= RW'(r2[c]);
            dv_w_q[j][c] <= {w_in[c][QB-2:0], 1'b0};
          end
        end
        dv_n_q[j] <= n_in;
        dv_ns_q[j] <= ns_in;
      end
    end
  end

  // clamp, sign and saturate
  logic signed [OutW-1:0] comp [4];
  logic [4:0] fin_ns;
  assign fin_ns = dv_ns_q[QB-1];

  always_comb begin
    logic [QW-1:0] qe;
    for (int c = 0; c < 4; c++) begin
      qe = QW'(dv_w_q[QB-1][c]);
      if (qe > QW'(CompMax)) begin
        qe = QW'(CompMax);
      end
      if (fin_ns[4]) begin
        comp[c] = '0;
      end else if (fin_ns[c]) begin
        comp[c] = OutW'(-qe);
      end else if (qe > QW'(PosMax)) begin
        comp[c] = OutW'(PosMax);
      end else begin
        comp[c] = OutW'(qe);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.quat_w <= comp[0];
      out_q.quat_x <= comp[1];
      out_q.quat_y <= comp[2];
      out_q.quat_z <= comp[3];
      out_q.degenerate <= fin_ns[4];
    end
  end

  // skid register catches a result the consumer did not take
  always_comb begin
    if (skid_q) begin
      skid_d = !out_ready_i;
    end else begin
      skid_d = vld_q[LST] && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else begin
      skid_q <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q) begin
      skid_data_q <= out_q;
    end
  end

  assign out_valid_o = skid_q || vld_q[LST];
  assign out_data_o = skid_q ? skid_data_q : out_q;

endmodule

FILE: sim/rmq_checker.sv
// checker that predicts quaternion results from observed matrix requests
`timescale 1ns / 1ps

module rmq_checker #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  rmq_pkg::mat_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  rmq_pkg::quat_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import rmq_pkg::*;

  quat_t quat_q[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] scale_part(longint v, longint unsigned n);
    longint unsigned mag;
    longint unsigned q;
    longint s;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag << FRAC_BITS) + (n >> 1)) / n;
    if (q > CompMax) q = CompMax;
    s = (v < 0) ? -longint'(q) : longint'(q);
    if (s > longint'(PosMax)) s = longint'(PosMax);
    return s[15:0];
  endfunction

  function automatic quat_t matrix_to_quat(mat_t m);
    quat_t r;
    longint one;
    longint t;
    longint a;
    longint v[4];
    longint unsigned sum;
    longint unsigned n;
    longint unsigned mag;
    one = longint'(1) << FRAC_BITS;
    t = longint'(m.m00) + m.m11 + m.m22;
    if (t > 0) begin
      a = one + t;
      v[0] = a; v[1] = longint'(m.m21) - m.m12;
      v[2] = longint'(m.m02) - m.m20; v[3] = longint'(m.m10) - m.m01;
    end else if (m.m00 > m.m11 && m.m00 > m.m22) begin
      a = one + m.m00 - m.m11 - m.m22;
      v[0] = longint'(m.m21) - m.m12; v[1] = a;
      v[2] = longint'(m.m01) + m.m10; v[3] = longint'(m.m02) + m.m20;
    end else if (m.m11 > m.m22) begin
      a = one + m.m11 - m.m00 - m.m22;
      v[0] = longint'(m.m02) - m.m20; v[1] = longint'(m.m01) + m.m10;
      v[2] = a; v[3] = longint'(m.m12) + m.m21;
    end else begin
      a = one + m.m22 - m.m00 - m.m11;
      v[0] = longint'(m.m10) - m.m01; v[1] = longint'(m.m02) + m.m20;
      v[2] = longint'(m.m12) + m.m21; v[3] = a;
    end
    r = '0;
    if (a <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      sum += mag * mag;
    end
    n = root_floor(sum);
    if (n == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.quat_w = scale_part(v[0], n);
    r.quat_x = scale_part(v[1], n);
    r.quat_y = scale_part(v[2], n);
    r.quat_z = scale_part(v[3], n);
    return r;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = quat_q.size();

  always @(posedge clk_i) begin
    quat_t exp_q;
    int errs;
    errs = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) quat_q.push_back(matrix_to_quat(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (quat_q.size() == 0) begin
          $error("result with no request waiting");
          errs++;
        end else begin
          exp_q = quat_q.pop_front();
          if (exp_q.quat_w !== out_data_i.quat_w) begin
            $error("quat_w expected %0d actual %0d", exp_q.quat_w, out_data_i.quat_w);
            errs++;
          end
          if (exp_q.quat_x !== out_data_i.quat_x) begin
            $error("quat_x expected %0d actual %0d", exp_q.quat_x, out_data_i.quat_x);
            errs++;
          end
          if (exp_q.quat_y !== out_data_i.quat_y) begin
            $error("quat_y expected %0d actual %0d", exp_q.quat_y, out_data_i.quat_y);
            errs++;
          end
          if (exp_q.quat_z !== out_data_i.quat_z) begin
            $error("quat_z expected %0d actual %0d", exp_q.quat_z, out_data_i.quat_z);
            errs++;
          end
          if (exp_q.degenerate !== out_data_i.degenerate) begin
            $error("degenerate expected %0d actual %0d", exp_q.degenerate,
                   out_data_i.degenerate);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

FILE: sim/rotation_matrix_to_quaternion_top_test.sv
// testbench top: matrix stimulus, output backpressure and verdict
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top_test;
  import rmq_pkg::*;

  localparam int unsigned FRAC_BITS = 14;
  localparam int NumRandom = 1600;
  localparam int CycleLimit = 400000;
  localparam int QuietTail = 300;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  mat_t  in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  quat_t out_data_o;
  int    fail_count;
  int    pending;
  int    sent = 0;
  int    cycle_count = 0;
  bit    quiet = 1'b0;
  mat_t  dir_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic signed [15:0] rand_elem();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'sh8000;
    if (sel == 1) return 16'sh7fff;
    if (sel < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
    return 16'($urandom);
  endfunction

  // near-rotation matrices (permutations with signs plus small noise), or in one case of four random elements
  function automatic mat_t rand_matrix();
    mat_t m;
    logic signed [15:0] e[9];
    int unsigned p;
    int cols[3];
    if ($urandom_range(0, 3) == 0) begin
      foreach (e[i]) e[i] = rand_elem();
    end else begin
      p = $urandom_range(0, 5);
      cols = '{p % 3, (p / 3 + 1 + p % 3) % 3, 0};
      if (cols[1] == cols[0]) cols[1] = (cols[0] + 1) % 3;
      cols[2] = 3 - cols[0] - cols[1];
      foreach (e[i]) e[i] = 16'($signed($urandom_range(0, 4000)) - 2000);
      for (int r = 0; r < 3; r++)
        e[r * 3 + cols[r]] = $urandom_range(0, 1) ? 16'sd16000 : -16'sd16000;
    end
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  task automatic send_request(mat_t m);
    in_valid_i <= 1'b1;
    in_data_i <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic idle_input();
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output backpressure in bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  initial begin
    mat_t m;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    dir_q.push_back('0);
    dir_q.push_back({9{16'sh7fff}});
    dir_q.push_back({9{16'sh8000}});
    // identity: trace branch
    dir_q.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, 16'sd16384});
    // x, y, z branches
    dir_q.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, -16'sd16384});
    dir_q.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, -16'sd16384});
    dir_q.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, 16'sd16384});
    // diagonal ties fall through to later branches
    dir_q.push_back({-16'sd8000, 16'sd5, 16'sd9, 16'sd3, -16'sd8000, 16'sd7,
                     16'sd1, 16'sd2, -16'sd9000});
    dir_q.push_back({-16'sd9000, 16'sd5, 16'sd9, 16'sd3, -16'sd9000, 16'sd7,
                     16'sd1, 16'sd2, -16'sd9000});
    // all-negative diagonal and a zero trace, both resolved in the z branch
    dir_q.push_back({16'sh8000, 16'sd100, 16'sd0, 16'sd0, 16'sh8000, 16'sd0,
                     16'sd0, 16'sd0, 16'sh8000});
    dir_q.push_back({-16'sd20000, 16'sd0, 16'sd0, 16'sd0, 16'sd10000, 16'sd0,
                     16'sd0, 16'sd0, 16'sd10000});
    // extreme off-diagonals in the trace branch and in the x branch
    dir_q.push_back({16'sd1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sh8000,
                     16'sh8000, 16'sh7fff, 16'sd0});
    dir_q.push_back({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
    foreach (dir_q[i]) begin
      send_request(dir_q[i]);
      idle_input();
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 200) quiet = 1'b1;
      m = rand_matrix();
      send_request(m);
      idle_input();
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (QuietTail) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/rmq_pkg.sv
hdl/rotation_matrix_to_quaternion_top.sv
sim/rmq_checker.sv
sim/rotation_matrix_to_quaternion_top_test.sv
